### rtl/bb3_pkg.sv
// Shared types and constants for the 3x3 RGB box blur.
// Used by every module of the block; no dependencies.
package bb3_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int PixW      = 8;
  localparam int Channels  = 3;
  localparam int Taps      = 9;
  localparam int WinRows   = 3;
  localparam int WinCols   = 2;
  localparam int SumW      = $clog2(Taps * ((1 << PixW) - 1) + 1);

  // mean = (sum * TapRecip) >> DivShift, exact for every sum below 2^SumW
  localparam int DivShift  = 16;
  localparam int TapRecip  = ((1 << DivShift) + Taps - 1) / Taps;
  localparam int RecipW    = $clog2(TapRecip + 1);
  localparam int ProdW     = SumW + RecipW;

  localparam int FrameRegW     = 11;
  localparam int MinSize       = 3;
  localparam int FrameWidthRst  = 640;
  localparam int FrameHeightRst = 480;
  localparam int WCmpW = (ColW + 1 > FrameRegW) ? ColW + 1 : FrameRegW;
  localparam int HCmpW = (RowW + 1 > FrameRegW) ? RowW + 1 : FrameRegW;
  localparam int OutPosW = 10;
  localparam int CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } cfg_reg_e;

  // channel 0 red, 1 green, 2 blue
  typedef logic [Channels-1:0][PixW-1:0] rgb_t;
  // one 3-pixel window column of a single channel, index 0 topmost
  typedef logic [WinRows-1:0][PixW-1:0] col_t;
  typedef col_t [WinCols-1:0] win_t;

  typedef struct packed {
    rgb_t older;
    rgb_t newer;
  } entry_t;

  typedef struct packed {
    logic            valid;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } pos_t;

  typedef struct packed {
    logic en;
    logic shift;
  } lane_ctl_t;

endpackage

### rtl/bb3_line_store.sv
// Paired line store (rows r-2 and r-1) with registered read and
// one-deep write forwarding. Depends on bb3_pkg.
module bb3_line_store (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [bb3_pkg::ColW-1:0] rd_addr_i,
  input  logic                  wr_en_i,
  input  logic [bb3_pkg::ColW-1:0] wr_addr_i,
  input  bb3_pkg::entry_t       wr_data_i,
  output bb3_pkg::entry_t       rd_data_o
);

  bb3_pkg::entry_t mem_q [bb3_pkg::MaxWidth];
  bb3_pkg::entry_t rd_q;
  bb3_pkg::entry_t fwd_data_q;
  logic            fwd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // a write landing on the same edge as the read is not seen by rd_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_hit_q ? fwd_data_q : rd_q;

endmodule

### rtl/bb3_lane.sv
// One color channel: 3x2 window history, nine-tap sum and divide by nine.
// Depends on bb3_pkg.
module bb3_lane (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bb3_pkg::lane_ctl_t       ctl_i,
  input  bb3_pkg::col_t            col_i,
  output logic [bb3_pkg::PixW-1:0] mean_o
);

  bb3_pkg::win_t                   win_q;
  logic [bb3_pkg::SumW-1:0]        sum_d;
  logic [bb3_pkg::SumW-1:0]        sum_q;
  logic [bb3_pkg::ProdW-1:0]       prod;

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < bb3_pkg::WinCols; k++) begin
      for (int i = 0; i < bb3_pkg::WinRows; i++) begin
        sum_d = sum_d + bb3_pkg::SumW'(win_q[k][i]);
      end
    end
    for (int i = 0; i < bb3_pkg::WinRows; i++) begin
      sum_d = sum_d + bb3_pkg::SumW'(col_i[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (ctl_i.shift) begin
      win_q[0] <= win_q[1];
      win_q[1] <= col_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      sum_q <= sum_d;
    end
  end

  assign prod   = bb3_pkg::ProdW'(sum_q) * bb3_pkg::ProdW'(bb3_pkg::TapRecip);
  assign mean_o = prod[bb3_pkg::DivShift +: bb3_pkg::PixW];

endmodule

### rtl/bb3_merge.sv
// Output register: joins the three lane means with the center position.
// Depends on bb3_pkg.
module bb3_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  bb3_pkg::pos_t               pos_i,
  input  bb3_pkg::rgb_t               mean_i,
  output logic                        valid_o,
  output logic [bb3_pkg::OutPosW-1:0] row_o,
  output logic [bb3_pkg::OutPosW-1:0] col_o,
  output bb3_pkg::rgb_t               mean_o
);

  logic                        valid_q;
  logic [bb3_pkg::OutPosW-1:0] row_q;
  logic [bb3_pkg::OutPosW-1:0] col_q;
  bb3_pkg::rgb_t               mean_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= pos_i.valid;
    end
  end

  // window center sits one row up and one column left of the newest pixel
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q  <= bb3_pkg::OutPosW'(pos_i.row - bb3_pkg::RowW'(1));
      col_q  <= bb3_pkg::OutPosW'(pos_i.col - bb3_pkg::ColW'(1));
      mean_q <= mean_i;
    end
  end

  assign valid_o = valid_q;
  assign row_o   = row_q;
  assign col_o   = col_q;
  assign mean_o  = mean_q;

endmodule

### rtl/box_blur_3x3_rgb.sv
// 3x3 box blur on an RGB raster stream, one pixel per cycle unless stalled.
// A completing pixel passes stage 1, the lane sum register with stage 2, and the output register.
// Throughput: one pixel per cycle unless stalled; the line store reads and writes once per cycle.
// Reset: a clearing pass over all 1024 line store entries (one entry per cycle) follows
// reset; in_stall_o stays high meanwhile, configuration writes are taken throughout.
module box_blur_3x3_rgb (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bb3_pkg::PixW-1:0]        red_in_i,
  input  logic [bb3_pkg::PixW-1:0]        green_in_i,
  input  logic [bb3_pkg::PixW-1:0]        blue_in_i,
  input  logic                            frame_start_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bb3_pkg::OutPosW-1:0]     out_row_o,
  output logic [bb3_pkg::OutPosW-1:0]     out_col_o,
  output logic [bb3_pkg::PixW-1:0]        red_out_o,
  output logic [bb3_pkg::PixW-1:0]        green_out_o,
  output logic [bb3_pkg::PixW-1:0]        blue_out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bb3_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [bb3_pkg::FrameRegW-1:0]   cfg_data_i
);

  logic [bb3_pkg::FrameRegW-1:0] frame_width_q;
  logic [bb3_pkg::FrameRegW-1:0] frame_height_q;
  logic [bb3_pkg::WCmpW-1:0]     fw;
  logic [bb3_pkg::WCmpW-1:0]     wcl;
  logic [bb3_pkg::HCmpW-1:0]     fh;
  logic [bb3_pkg::HCmpW-1:0]     hcl;

  logic                          clr_busy_q;
  logic [bb3_pkg::ColW-1:0]      clr_cnt_q;

  logic                          en;
  logic                          accept;
  logic [bb3_pkg::RowW-1:0]      row_q;
  logic [bb3_pkg::ColW-1:0]      col_q;
  logic [bb3_pkg::RowW-1:0]      r0;
  logic [bb3_pkg::ColW-1:0]      c0;

  bb3_pkg::pos_t                 s1_q;
  logic                          s1_emit_q;
  bb3_pkg::rgb_t                 s1_px_q;
  bb3_pkg::pos_t                 s2_q;

  logic                          wr_en;
  logic [bb3_pkg::ColW-1:0]      wr_addr;
  bb3_pkg::entry_t               wr_data;
  bb3_pkg::entry_t               rd_entry;

  bb3_pkg::lane_ctl_t            lane_ctl;
  bb3_pkg::col_t                 newcol [bb3_pkg::Channels];
  bb3_pkg::rgb_t                 mean;
  bb3_pkg::rgb_t                 mean_out;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= bb3_pkg::FrameRegW'(bb3_pkg::FrameWidthRst);
      frame_height_q <= bb3_pkg::FrameRegW'(bb3_pkg::FrameHeightRst);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bb3_pkg::cfg_reg_e'(cfg_index_i))
        bb3_pkg::RegFrameWidth:  frame_width_q  <= cfg_data_i;
        bb3_pkg::RegFrameHeight: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    fw = bb3_pkg::WCmpW'(frame_width_q);
    if (fw < bb3_pkg::WCmpW'(bb3_pkg::MinSize)) begin
      wcl = bb3_pkg::WCmpW'(bb3_pkg::MinSize);
    end else if (fw > bb3_pkg::WCmpW'(bb3_pkg::MaxWidth)) begin
      wcl = bb3_pkg::WCmpW'(bb3_pkg::MaxWidth);
    end else begin
      wcl = fw;
    end
    fh = bb3_pkg::HCmpW'(frame_height_q);
    if (fh < bb3_pkg::HCmpW'(bb3_pkg::MinSize)) begin
      hcl = bb3_pkg::HCmpW'(bb3_pkg::MinSize);
    end else if (fh > bb3_pkg::HCmpW'(bb3_pkg::MaxHeight)) begin
      hcl = bb3_pkg::HCmpW'(bb3_pkg::MaxHeight);
    end else begin
      hcl = fh;
    end
  end

  // line store clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == bb3_pkg::ColW'(bb3_pkg::MaxWidth - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + bb3_pkg::ColW'(1);
      end
    end
  end

  // whole pipeline advances together; the output register parts the sides
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = clr_busy_q || !en;
  assign accept     = in_valid_i && !in_stall_o;

  // position of the arriving pixel
  assign r0 = frame_start_i ? '0 : row_q;
  assign c0 = frame_start_i ? '0 : col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      if (bb3_pkg::WCmpW'(c0) + bb3_pkg::WCmpW'(1) >= wcl) begin
        col_q <= '0;
        if (bb3_pkg::HCmpW'(r0) + bb3_pkg::HCmpW'(1) >= hcl) begin
          row_q <= '0;
        end else begin
          row_q <= r0 + bb3_pkg::RowW'(1);
        end
      end else begin
        col_q <= c0 + bb3_pkg::ColW'(1);
        row_q <= r0;
      end
    end
  end

  // stage 1: pixel plus line store entry read at its column; stage 2: position of a window to emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (en) begin
      s1_q.valid <= accept;
      s1_q.row   <= r0;
      s1_q.col   <= c0;
      s2_q.valid <= s1_q.valid && s1_emit_q;
      s2_q.row   <= s1_q.row;
      s2_q.col   <= s1_q.col;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_emit_q  <= (r0 >= bb3_pkg::RowW'(2)) && (c0 >= bb3_pkg::ColW'(2));
      s1_px_q[0] <= red_in_i;
      s1_px_q[1] <= green_in_i;
      s1_px_q[2] <= blue_in_i;
    end
  end

  // column shifts up by one row in the store; zeros are written during the clearing pass
  assign wr_en        = clr_busy_q || (en && s1_q.valid);
  assign wr_addr      = clr_busy_q ? clr_cnt_q : s1_q.col;
  assign wr_data      = clr_busy_q ? '0 : bb3_pkg::entry_t'({rd_entry.newer, s1_px_q});

  bb3_line_store u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (en),
    .rd_addr_i (c0),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_entry)
  );

  always_comb begin
    for (int ch = 0; ch < bb3_pkg::Channels; ch++) begin
      newcol[ch][0] = rd_entry.older[ch];
      newcol[ch][1] = rd_entry.newer[ch];
      newcol[ch][2] = s1_px_q[ch];
    end
  end

  assign lane_ctl.en    = en;
  assign lane_ctl.shift = en && s1_q.valid;

  for (genvar ch = 0; ch < bb3_pkg::Channels; ch++) begin : g_lane
    bb3_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (lane_ctl),
      .col_i  (newcol[ch]),
      .mean_o (mean[ch])
    );
  end

  bb3_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .pos_i   (s2_q),
    .mean_i  (mean),
    .valid_o (out_valid_o),
    .row_o   (out_row_o),
    .col_o   (out_col_o),
    .mean_o  (mean_out)
  );

  assign red_out_o   = mean_out[0];
  assign green_out_o = mean_out[1];
  assign blue_out_o  = mean_out[2];

`ifndef SYNTH
  // nothing is in flight while the line store is being cleared
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (!out_valid_o && !s1_q.valid && !s2_q.valid))
    else $error("pipeline busy during clearing pass");

  a_emit_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s1_q.valid && s1_emit_q) |=> s2_q.valid)
    else $error("interior pixel lost between stage 1 and stage 2");

  a_s2_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s2_q.valid) |=> out_valid_o)
    else $error("result lost at output register");
`endif

endmodule

### bench/box_blur_3x3_rgb_tb.sv
// Self-checking bench for box_blur_3x3_rgb: random and directed RGB raster frames,
// predicted 3x3 means compared per field. Depends on rtl/bb3_pkg.sv and the block.
module box_blur_3x3_rgb_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [bb3_pkg::OutPosW-1:0] out_row;
    logic [bb3_pkg::OutPosW-1:0] out_col;
    logic [bb3_pkg::PixW-1:0]    red_out;
    logic [bb3_pkg::PixW-1:0]    green_out;
    logic [bb3_pkg::PixW-1:0]    blue_out;
  } blur_result_t;

  class blur_scoreboard;
    bb3_pkg::rgb_t                 older_line [bb3_pkg::MaxWidth];
    bb3_pkg::rgb_t                 newer_line [bb3_pkg::MaxWidth];
    // [0] older column, row 0 topmost
    bb3_pkg::rgb_t                 win [bb3_pkg::WinCols][bb3_pkg::WinRows];
    logic [bb3_pkg::FrameRegW-1:0] width_reg;
    logic [bb3_pkg::FrameRegW-1:0] height_reg;
    int unsigned                   row_pos;
    int unsigned                   col_pos;
    blur_result_t                  pending_means [$];
    int                            errors;

    function new();
      for (int i = 0; i < bb3_pkg::MaxWidth; i++) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      for (int k = 0; k < bb3_pkg::WinCols; k++) begin
        for (int i = 0; i < bb3_pkg::WinRows; i++) win[k][i] = '0;
      end
      width_reg  = bb3_pkg::FrameRegW'(bb3_pkg::FrameWidthRst);
      height_reg = bb3_pkg::FrameRegW'(bb3_pkg::FrameHeightRst);
      row_pos    = 0;
      col_pos    = 0;
      errors     = 0;
    endfunction

    function int unsigned clamp_size(logic [bb3_pkg::FrameRegW-1:0] v, int unsigned hi);
      if (32'(v) < bb3_pkg::MinSize) return bb3_pkg::MinSize;
      if (32'(v) > hi) return hi;
      return 32'(v);
    endfunction

    function void write_reg(bb3_pkg::cfg_reg_e idx, logic [bb3_pkg::FrameRegW-1:0] v);
      case (idx)
        bb3_pkg::RegFrameWidth:  width_reg = v;
        bb3_pkg::RegFrameHeight: height_reg = v;
        default: ;
      endcase
    endfunction

    function void note_pixel(bb3_pkg::rgb_t px, logic frame_start);
      int unsigned   w, h, r, c, sum;
      bb3_pkg::rgb_t ncol [bb3_pkg::WinRows];
      blur_result_t  res;
      w = clamp_size(width_reg, bb3_pkg::MaxWidth);
      h = clamp_size(height_reg, bb3_pkg::MaxHeight);
      if (frame_start) begin
        row_pos = 0;
        col_pos = 0;
      end
      r = row_pos;
      c = col_pos % bb3_pkg::MaxWidth;
      ncol[0] = older_line[c];
      ncol[1] = newer_line[c];
      ncol[2] = px;
      if (r >= 2 && c >= 2) begin
        for (int ch = 0; ch < bb3_pkg::Channels; ch++) begin
          sum = 0;
          for (int i = 0; i < bb3_pkg::WinRows; i++) begin
            sum += win[0][i][ch] + win[1][i][ch] + ncol[i][ch];
          end
          case (ch)
            0:       res.red_out   = bb3_pkg::PixW'(sum / bb3_pkg::Taps);
            1:       res.green_out = bb3_pkg::PixW'(sum / bb3_pkg::Taps);
            default: res.blue_out  = bb3_pkg::PixW'(sum / bb3_pkg::Taps);
          endcase
        end
        res.out_row = bb3_pkg::OutPosW'(r - 1);
        res.out_col = bb3_pkg::OutPosW'(c - 1);
        pending_means.push_back(res);
      end
      older_line[c] = newer_line[c];
      newer_line[c] = px;
      win[0] = win[1];
      win[1] = ncol;
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(blur_result_t got);
      blur_result_t exp_r;
      if (pending_means.size() == 0) begin
        $error("result with nothing expected: row %0d col %0d", got.out_row, got.out_col);
        errors++;
        return;
      end
      exp_r = pending_means.pop_front();
      compare_field("out_row", 32'(exp_r.out_row), 32'(got.out_row));
      compare_field("out_col", 32'(exp_r.out_col), 32'(got.out_col));
      compare_field("red_out", 32'(exp_r.red_out), 32'(got.red_out));
      compare_field("green_out", 32'(exp_r.green_out), 32'(got.green_out));
      compare_field("blue_out", 32'(exp_r.blue_out), 32'(got.blue_out));
    endfunction

    function int pending();
      return pending_means.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [bb3_pkg::PixW-1:0]      red_in = '0;
  logic [bb3_pkg::PixW-1:0]      green_in = '0;
  logic [bb3_pkg::PixW-1:0]      blue_in = '0;
  logic                          frame_start = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [bb3_pkg::OutPosW-1:0]   out_row;
  logic [bb3_pkg::OutPosW-1:0]   out_col;
  logic [bb3_pkg::PixW-1:0]      red_out;
  logic [bb3_pkg::PixW-1:0]      green_out;
  logic [bb3_pkg::PixW-1:0]      blue_out;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [bb3_pkg::CfgIdxW-1:0]   cfg_index = '0;
  logic [bb3_pkg::FrameRegW-1:0] cfg_data = '0;

  blur_scoreboard sb = new();
  int             src_idle_pct = 0;
  int             sink_stall_pct = 0;
  int             cycle_count = 0;

  box_blur_3x3_rgb i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .red_in_i      (red_in),
    .green_in_i    (green_in),
    .blue_in_i     (blue_in),
    .frame_start_i (frame_start),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_row_o     (out_row),
    .out_col_o     (out_col),
    .red_out_o     (red_out),
    .green_out_o   (green_out),
    .blue_out_o    (blue_out),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver side: random stall, check every result transfer
  always @(negedge clk) begin
    out_stall <= (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result('{out_row, out_col, red_out, green_out, blue_out});
    end
  end

  function automatic bb3_pkg::rgb_t rand_px();
    bb3_pkg::rgb_t px;
    for (int ch = 0; ch < bb3_pkg::Channels; ch++) begin
      case ($urandom_range(7))
        0:       px[ch] = '0;
        1:       px[ch] = '1;
        default: px[ch] = bb3_pkg::PixW'($urandom);
      endcase
    end
    return px;
  endfunction

  task automatic send_pixel(bb3_pkg::rgb_t px, logic fs);
    @(negedge clk);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    red_in      <= px[0];
    green_in    <= px[1];
    blue_in     <= px[2];
    frame_start <= fs;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(px, fs);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // block idle: nothing pending, plus a wait for a pixel still in flight
  task automatic settle();
    hold_until_drained();
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(bb3_pkg::cfg_reg_e idx, logic [bb3_pkg::FrameRegW-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_stream(int n);
    for (int i = 0; i < n; i++) send_pixel(rand_px(), 1'b0);
  endtask

  // mostly whole frames; now and then a frame cut short or a stray pixel
  task automatic send_frames(int n_items, int w, int h);
    int done;
    int k;
    done = 0;
    while (done < n_items) begin
      for (k = 0; k < w * h && done < n_items; k++) begin
        if ($urandom_range(199) == 0) hold_until_drained();
        if (k > 0 && $urandom_range(99) < 2) break;
        send_pixel(rand_px(), k == 0);
        done++;
        if ($urandom_range(99) < 2) begin
          send_pixel(rand_px(), 1'($urandom_range(1)));
          done++;
        end
      end
    end
  endtask

  initial begin
    int            w;
    int            h;
    bb3_pkg::rgb_t px;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // taken during the clearing pass
    write_reg(bb3_pkg::RegFrameWidth, 11'd3);
    write_reg(bb3_pkg::RegFrameHeight, 11'd3);

    // directed: saturated frame, then a frame restarted after two pixels
    for (int i = 0; i < 9; i++) send_pixel('1, i == 0);
    send_pixel('0, 1'b0);
    send_pixel('0, 1'b0);
    for (int i = 0; i < 9; i++) begin
      px[0] = '0;
      px[1] = '1;
      px[2] = bb3_pkg::PixW'(i * 31);
      send_pixel(px, i == 0);
    end

    // sizes below the minimum act as 3
    settle();
    write_reg(bb3_pkg::RegFrameWidth, 11'd0);
    write_reg(bb3_pkg::RegFrameHeight, 11'd0);
    src_idle_pct = 54;
    send_frames(150, 3, 3);

    settle();
    write_reg(bb3_pkg::RegFrameWidth, 11'd7);
    write_reg(bb3_pkg::RegFrameHeight, 11'd5);
    src_idle_pct   = 0;
    sink_stall_pct = 54;
    send_frames(150, 7, 5);

    settle();
    w = $urandom_range(20, 3);
    h = $urandom_range(12, 3);
    write_reg(bb3_pkg::RegFrameWidth, bb3_pkg::FrameRegW'(w));
    write_reg(bb3_pkg::RegFrameHeight, bb3_pkg::FrameRegW'(h));
    src_idle_pct   = 33;
    sink_stall_pct = 33;
    send_frames(150, w, h);

    // full-width row: climb two rows at width 3, then widen mid-frame
    settle();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    write_reg(bb3_pkg::RegFrameWidth, 11'd3);
    write_reg(bb3_pkg::RegFrameHeight, 11'd1024);
    send_pixel(rand_px(), 1'b1);
    send_stream(5);
    settle();
    write_reg(bb3_pkg::RegFrameWidth, 11'd1024);
    send_stream(512);
    settle();
    write_reg(bb3_pkg::RegFrameWidth, 11'd2047);
    send_stream(518);

    // shrink both sizes below the current position
    settle();
    write_reg(bb3_pkg::RegFrameWidth, 11'd4);
    write_reg(bb3_pkg::RegFrameHeight, 11'd3);
    src_idle_pct   = 33;
    sink_stall_pct = 33;
    send_stream(40);

    // tall frame: height register above the maximum
    settle();
    write_reg(bb3_pkg::RegFrameWidth, 11'd3);
    write_reg(bb3_pkg::RegFrameHeight, 11'd2047);
    src_idle_pct   = 0;
    sink_stall_pct = 54;
    send_pixel(rand_px(), 1'b1);
    send_stream(29);

    settle();
    w = $urandom_range(12, 3);
    h = $urandom_range(6, 3);
    write_reg(bb3_pkg::RegFrameWidth, bb3_pkg::FrameRegW'(w));
    write_reg(bb3_pkg::RegFrameHeight, bb3_pkg::FrameRegW'(h));
    sink_stall_pct = 0;
    send_frames(150, w, h);

    hold_until_drained();
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
